// ----- rtl/pidpi_pkg.sv -----
// ----------------------------------------------------------------------------
// pidpi_pkg: shared types and constants of the PID controller
// Field widths, register codes, reset values and the stage-to-stage bundles.
// ----------------------------------------------------------------------------
package pidpi_pkg;

    localparam int GAIN_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int DIFF1_W  = ERR_W + 1;
    localparam int DIFF2_W  = ERR_W + 2;
    localparam int LIMIT_W  = 32;
    localparam int TERM_W   = 40;
    localparam int SUM_W    = TERM_W + 2;
    localparam int FRAC_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int unsigned DEADZONE_DEFAULT = 0;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    localparam logic signed [LIMIT_W-1:0] LIMIT_MIN = {1'b1, {(LIMIT_W-1){1'b0}}};
    localparam logic signed [LIMIT_W-1:0] LIMIT_MAX = {1'b0, {(LIMIT_W-1){1'b1}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_OUT_LOW    = 3'd3,
        CFG_OUT_HIGH   = 3'd4,
        CFG_INTEG_LOW  = 3'd5,
        CFG_INTEG_HIGH = 3'd6,
        CFG_LOOP_MODE  = 3'd7
    } cfg_index_t;

    // Gains and limits as the datapath sees them: limit pairs already in order.
    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [LIMIT_W-1:0] out_lo;
        logic signed [LIMIT_W-1:0] out_hi;
        logic signed [LIMIT_W-1:0] integ_lo;
        logic signed [LIMIT_W-1:0] integ_hi;
        logic                      loop_mode;
    } cfg_t;

    typedef struct packed {
        logic                      clear;
        logic signed [DIFF1_W-1:0] op_p;
        logic signed [LIMIT_W-1:0] op_i;
        logic signed [DIFF2_W-1:0] op_d;
    } ops_t;

    typedef struct packed {
        logic                     clear;
        logic signed [TERM_W-1:0] p;
        logic signed [TERM_W-1:0] i;
        logic signed [TERM_W-1:0] d;
    } terms_t;

endpackage

// ----- rtl/pid_positional_incremental.sv -----
// ----------------------------------------------------------------------------
// pid_positional_incremental: PID controller, positional and incremental form
// Top level: configuration registers and the three-stage datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request carries a command, a setpoint and a measurement; each
//   one produces exactly one result request with the three scaled terms and
//   the clamped drive. A clear command zeroes the stored state and returns
//   an all-zero result.
//   Configuration writes (index and data) are always taken, and any write
//   also zeroes the stored state. Write only while no request is in flight.
//   A result passes the input register, operand register, product register
//   and output register. Throughput: one request per cycle while the
//   receiver does not stall; the integral and error
//   history close their loop in the operand stage, the held output in the
//   output stage, so back-to-back requests need no spacing.
//   When the receiver stalls, the pipeline keeps filling its empty stages
//   and in_ready drops only once every stage holds a request.
//   Reset (rst_n low, asynchronous) empties the pipeline, zeroes the state
//   and loads zero gains, full-range limits and the positional form.
// ----------------------------------------------------------------------------
module pid_positional_incremental
    import pidpi_pkg::*;
#(
    parameter int unsigned DEADZONE = DEADZONE_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic signed [SAMPLE_W-1:0] target,
    input  logic signed [SAMPLE_W-1:0] measured,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [TERM_W-1:0]   p_term,
    output logic signed [TERM_W-1:0]   i_term,
    output logic signed [TERM_W-1:0]   d_term,
    output logic signed [LIMIT_W-1:0]  drive,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    cfg_t   cfg;
    logic   cfg_wr;
    logic   ops_valid, terms_valid;
    logic   mult_free, out_free;
    ops_t   ops;
    terms_t terms;

    pidpi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_wr    (cfg_wr),
        .cfg       (cfg)
    );

    pidpi_err_stage #(
        .DEADZONE (DEADZONE)
    ) u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_wr    (cfg_wr),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .target    (target),
        .measured  (measured),
        .down_free (mult_free),
        .ops_valid (ops_valid),
        .ops       (ops)
    );

    pidpi_mult_stage u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .ops_valid   (ops_valid),
        .ops         (ops),
        .free        (mult_free),
        .down_free   (out_free),
        .terms_valid (terms_valid),
        .terms       (terms)
    );

    pidpi_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cfg_wr      (cfg_wr),
        .terms_valid (terms_valid),
        .terms       (terms),
        .free        (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .p_term      (p_term),
        .i_term      (i_term),
        .d_term      (d_term),
        .drive       (drive)
    );

endmodule

// ----- rtl/pidpi_cfg.sv -----
// ----------------------------------------------------------------------------
// pidpi_cfg: configuration registers
// Holds gains, limits and mode; presents the limit pairs sorted low/high.
// ----------------------------------------------------------------------------
module pidpi_cfg
    import pidpi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  cfg_wr,
    output cfg_t                  cfg
);

    logic signed [GAIN_W-1:0]  gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [LIMIT_W-1:0] out_low_reg, out_high_reg;
    logic signed [LIMIT_W-1:0] integ_low_reg, integ_high_reg;
    logic                      loop_mode_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            out_low_reg    <= LIMIT_MIN;
            out_high_reg   <= LIMIT_MAX;
            integ_low_reg  <= LIMIT_MIN;
            integ_high_reg <= LIMIT_MAX;
            loop_mode_reg  <= MODE_POSITIONAL;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_GAIN_P:     gain_p_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:     gain_i_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:     gain_d_reg     <= cfg_data[GAIN_W-1:0];
                CFG_OUT_LOW:    out_low_reg    <= cfg_data[LIMIT_W-1:0];
                CFG_OUT_HIGH:   out_high_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_INTEG_LOW:  integ_low_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_INTEG_HIGH: integ_high_reg <= cfg_data[LIMIT_W-1:0];
                CFG_LOOP_MODE:  loop_mode_reg  <= cfg_data[0];
                default:        loop_mode_reg  <= loop_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.gain_p    = gain_p_reg;
        cfg.gain_i    = gain_i_reg;
        cfg.gain_d    = gain_d_reg;
        cfg.loop_mode = loop_mode_reg;
        // A pair written out of order is used swapped; the registers keep it.
        if (out_low_reg > out_high_reg)
        begin
            cfg.out_lo = out_high_reg;
            cfg.out_hi = out_low_reg;
        end
        else
        begin
            cfg.out_lo = out_low_reg;
            cfg.out_hi = out_high_reg;
        end
        if (integ_low_reg > integ_high_reg)
        begin
            cfg.integ_lo = integ_high_reg;
            cfg.integ_hi = integ_low_reg;
        end
        else
        begin
            cfg.integ_lo = integ_low_reg;
            cfg.integ_hi = integ_high_reg;
        end
    end

endmodule

// ----- rtl/pidpi_err_stage.sv -----
// ----------------------------------------------------------------------------
// pidpi_err_stage: input register, error, deadzone and error history
// Forms the error, updates the integral and error history, and registers the
// three multiplier operands for the selected loop form.
// ----------------------------------------------------------------------------
module pidpi_err_stage
    import pidpi_pkg::*;
#(
    parameter int unsigned DEADZONE = DEADZONE_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       cfg_wr,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic signed [SAMPLE_W-1:0] target,
    input  logic signed [SAMPLE_W-1:0] measured,
    input  logic                       down_free,
    output logic                       ops_valid,
    output ops_t                       ops
);

    localparam logic [ERR_W-1:0] DZ = ERR_W'(DEADZONE);

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_command_reg;
    logic signed [SAMPLE_W-1:0] s1_target_reg, s1_measured_reg;
    logic                       ops_valid_reg, ops_valid_next;
    ops_t                       ops_reg, ops_next;
    logic signed [LIMIT_W-1:0]  integ_reg, integ_next;
    logic signed [ERR_W-1:0]    last_err_reg, last_err_next;
    logic signed [ERR_W-1:0]    prev_err_reg, prev_err_next;

    logic                       ops_free, s1_move, in_fire;
    logic signed [ERR_W-1:0]    err_raw, err;
    logic [ERR_W-1:0]           err_mag;
    logic signed [LIMIT_W:0]    integ_sum;
    logic signed [LIMIT_W-1:0]  integ_lo, integ_hi, integ_new;
    logic signed [DIFF1_W-1:0]  diff1;
    logic signed [DIFF2_W-1:0]  diff2;

    assign ops_free  = !ops_valid_reg || down_free;
    assign s1_move   = s1_valid_reg && ops_free;
    assign in_ready  = !s1_valid_reg || ops_free;
    assign in_fire   = in_valid && in_ready;
    assign ops_valid = ops_valid_reg;
    assign ops       = ops_reg;
    assign integ_lo  = cfg.integ_lo;
    assign integ_hi  = cfg.integ_hi;

    always_comb
    begin
        err_raw = ERR_W'(s1_target_reg) - ERR_W'(s1_measured_reg);
        err_mag = err_raw[ERR_W-1] ? unsigned'(-err_raw) : unsigned'(err_raw);
        err     = (err_mag < DZ) ? '0 : err_raw;

        integ_sum = (LIMIT_W+1)'(integ_reg) + (LIMIT_W+1)'(err);
        if (integ_sum < (LIMIT_W+1)'(integ_lo))
            integ_new = integ_lo;
        else if (integ_sum > (LIMIT_W+1)'(integ_hi))
            integ_new = integ_hi;
        else
            integ_new = integ_sum[LIMIT_W-1:0];

        diff1 = DIFF1_W'(err) - DIFF1_W'(last_err_reg);
        diff2 = DIFF2_W'(err) - (DIFF2_W'(last_err_reg) <<< 1) + DIFF2_W'(prev_err_reg);
    end

    always_comb
    begin
        ops_next = '0;
        if (s1_command_reg == CMD_CLEAR)
            ops_next.clear = 1'b1;
        else if (cfg.loop_mode == MODE_POSITIONAL)
        begin
            ops_next.op_p = DIFF1_W'(err);
            ops_next.op_i = integ_new;
            ops_next.op_d = DIFF2_W'(diff1);
        end
        else
        begin
            ops_next.op_p = diff1;
            ops_next.op_i = LIMIT_W'(err);
            ops_next.op_d = diff2;
        end
    end

    always_comb
    begin
        s1_valid_next  = in_ready ? in_valid : s1_valid_reg;
        ops_valid_next = ops_free ? s1_valid_reg : ops_valid_reg;
        integ_next     = integ_reg;
        last_err_next  = last_err_reg;
        prev_err_next  = prev_err_reg;
        if (cfg_wr || (s1_move && s1_command_reg == CMD_CLEAR))
        begin
            integ_next    = '0;
            last_err_next = '0;
            prev_err_next = '0;
        end
        else if (s1_move)
        begin
            if (cfg.loop_mode == MODE_POSITIONAL)
                integ_next = integ_new;
            else
                prev_err_next = last_err_reg;
            last_err_next = err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            ops_valid_reg <= 1'b0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            prev_err_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            ops_valid_reg <= ops_valid_next;
            integ_reg     <= integ_next;
            last_err_reg  <= last_err_next;
            prev_err_reg  <= prev_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_command_reg  <= command;
            s1_target_reg   <= target;
            s1_measured_reg <= measured;
        end
        if (s1_move)
            ops_reg <= ops_next;
    end

    // A clear request must leave no trace of history behind it.
    a_clear_history: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_command_reg == CMD_CLEAR)
            |=> (integ_reg == '0 && last_err_reg == '0 && prev_err_reg == '0))
        else $error("error history not cleared");

    // The positional integral operand always lies inside the integral limits.
    a_integ_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ops_valid_reg && !ops_reg.clear && cfg.loop_mode == MODE_POSITIONAL)
            |-> (ops_reg.op_i >= integ_lo && ops_reg.op_i <= integ_hi))
        else $error("integral operand outside limits");

endmodule

// ----- rtl/pidpi_mult_stage.sv -----
// ----------------------------------------------------------------------------
// pidpi_mult_stage: gain multipliers
// Three signed gain products, scaled down by the Q8.8 fraction and registered.
// ----------------------------------------------------------------------------
module pidpi_mult_stage
    import pidpi_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   ops_valid,
    input  ops_t   ops,
    output logic   free,
    input  logic   down_free,
    output logic   terms_valid,
    output terms_t terms
);

    localparam int PROD_P_W = GAIN_W + DIFF1_W;
    localparam int PROD_I_W = GAIN_W + LIMIT_W;
    localparam int PROD_D_W = GAIN_W + DIFF2_W;

    logic                       terms_valid_reg, terms_valid_next;
    terms_t                     terms_reg, terms_next;
    logic                       move;
    logic signed [GAIN_W-1:0]   gain_p, gain_i, gain_d;
    logic signed [DIFF1_W-1:0]  op_p;
    logic signed [LIMIT_W-1:0]  op_i;
    logic signed [DIFF2_W-1:0]  op_d;
    logic signed [PROD_P_W-1:0] prod_p;
    logic signed [PROD_I_W-1:0] prod_i;
    logic signed [PROD_D_W-1:0] prod_d;

    assign free        = !terms_valid_reg || down_free;
    assign move        = ops_valid && free;
    assign terms_valid = terms_valid_reg;
    assign terms       = terms_reg;

    assign gain_p = cfg.gain_p;
    assign gain_i = cfg.gain_i;
    assign gain_d = cfg.gain_d;
    assign op_p   = ops.op_p;
    assign op_i   = ops.op_i;
    assign op_d   = ops.op_d;

    assign prod_p = PROD_P_W'(gain_p) * PROD_P_W'(op_p);
    assign prod_i = PROD_I_W'(gain_i) * PROD_I_W'(op_i);
    assign prod_d = PROD_D_W'(gain_d) * PROD_D_W'(op_d);

    // Arithmetic shift rounds toward minus infinity.
    always_comb
    begin
        terms_next.clear = ops.clear;
        terms_next.p     = TERM_W'(prod_p >>> FRAC_W);
        terms_next.i     = TERM_W'(prod_i >>> FRAC_W);
        terms_next.d     = TERM_W'(prod_d >>> FRAC_W);
        terms_valid_next = free ? ops_valid : terms_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            terms_valid_reg <= 1'b0;
        else
            terms_valid_reg <= terms_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (move)
            terms_reg <= terms_next;
    end

endmodule

// ----- rtl/pidpi_out_stage.sv -----
// ----------------------------------------------------------------------------
// pidpi_out_stage: output sum, clamp and held output
// Adds the terms (and the held output in incremental form), clamps the sum,
// registers the result; incremental form updates the held output if unclamped.
// ----------------------------------------------------------------------------
module pidpi_out_stage
    import pidpi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      cfg_wr,
    input  logic                      terms_valid,
    input  terms_t                    terms,
    output logic                      free,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [TERM_W-1:0]  p_term,
    output logic signed [TERM_W-1:0]  i_term,
    output logic signed [TERM_W-1:0]  d_term,
    output logic signed [LIMIT_W-1:0] drive
);

    logic                      out_valid_reg, out_valid_next;
    logic                      out_clear_reg;
    logic signed [TERM_W-1:0]  p_reg, i_reg, d_reg;
    logic signed [LIMIT_W-1:0] drive_reg, drive_next;
    logic signed [LIMIT_W-1:0] held_reg, held_next;
    logic                      move, incremental, in_range;
    logic signed [LIMIT_W-1:0] out_lo, out_hi;
    logic signed [SUM_W-1:0]   held_ext, sum;

    assign free        = !out_valid_reg || out_ready;
    assign move        = terms_valid && free;
    assign incremental = (cfg.loop_mode == MODE_INCREMENTAL);
    assign out_lo      = cfg.out_lo;
    assign out_hi      = cfg.out_hi;

    assign out_valid = out_valid_reg;
    assign p_term    = p_reg;
    assign i_term    = i_reg;
    assign d_term    = d_reg;
    assign drive     = drive_reg;

    always_comb
    begin
        held_ext = incremental ? SUM_W'(held_reg) : '0;
        sum      = held_ext + SUM_W'(terms.p) + SUM_W'(terms.i) + SUM_W'(terms.d);
        in_range = 1'b0;
        if (terms.clear)
            drive_next = '0;
        else if (sum < SUM_W'(out_lo))
            drive_next = out_lo;
        else if (sum > SUM_W'(out_hi))
            drive_next = out_hi;
        else
        begin
            drive_next = sum[LIMIT_W-1:0];
            in_range   = 1'b1;
        end

        // Anti-windup: the held output follows only an unclamped sum.
        held_next = held_reg;
        if (cfg_wr || (move && terms.clear))
            held_next = '0;
        else if (move && incremental && in_range)
            held_next = drive_next;

        out_valid_next = free ? terms_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_clear_reg <= terms.clear;
            p_reg         <= terms.p;
            i_reg         <= terms.i;
            d_reg         <= terms.d;
            drive_reg     <= drive_next;
        end
    end

    a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_clear_reg) |-> (drive_reg >= out_lo && drive_reg <= out_hi))
        else $error("drive outside output limits");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (move && terms.clear) |=> (held_reg == '0 && drive_reg == '0))
        else $error("clear request did not zero the output");

    a_held_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (move && incremental && !terms.clear && in_range && !cfg_wr)
            |=> (held_reg == drive_reg))
        else $error("held output does not follow an unclamped drive");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the positional and incremental PID controller
// Drives sample requests and register writes over valid/ready handshakes,
// with random idling on both sides. A local model predicts every result that
// the directed table does not list; each result is compared field by field.
// The directed cases run first, followed by random phases with new settings.
// ----------------------------------------------------------------------------
module tb
    import pidpi_pkg::*;
();

    localparam int CYCLE_LIMIT     = 500000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int DRAIN_CYCLES    = 8;

    typedef struct packed {
        logic signed [TERM_W-1:0]  p;
        logic signed [TERM_W-1:0]  i;
        logic signed [TERM_W-1:0]  d;
        logic signed [LIMIT_W-1:0] drive;
    } pid_result_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        cfg_index_t                 idx;
        logic [CFG_DATA_W-1:0]      data;
        logic                       cmd;
        logic signed [SAMPLE_W-1:0] tgt;
        logic signed [SAMPLE_W-1:0] meas;
        bit                         typed;
        pid_result_t                want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = CMD_UPDATE;
    logic signed [SAMPLE_W-1:0] target = '0;
    logic signed [SAMPLE_W-1:0] measured = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [TERM_W-1:0] p_term;
    logic signed [TERM_W-1:0] i_term;
    logic signed [TERM_W-1:0] d_term;
    logic signed [LIMIT_W-1:0] drive;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Settings and loop state as the controller should hold them.
    logic signed [GAIN_W-1:0]  cur_kp, cur_ki, cur_kd;
    logic signed [LIMIT_W-1:0] cur_out_lo, cur_out_hi, cur_int_lo, cur_int_hi;
    logic                      cur_mode;
    logic signed [LIMIT_W-1:0] integ_acc;
    logic signed [ERR_W-1:0]   err_last, err_prev;
    logic signed [LIMIT_W-1:0] held_drive;

    pid_result_t pending_results[$];
    row_t        directed_rows[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pid_positional_incremental i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .target    (target),
        .measured  (measured),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .p_term    (p_term),
        .i_term    (i_term),
        .d_term    (d_term),
        .drive     (drive),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic report_mismatch(string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint clamp_to(longint x, longint a, longint b);
        longint lo, hi;
        lo = (a > b) ? b : a;
        hi = (a > b) ? a : b;
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    function automatic void clear_history();
        integ_acc  = '0;
        err_last   = '0;
        err_prev   = '0;
        held_drive = '0;
    endfunction

    function automatic void reset_settings();
        cur_kp     = '0;
        cur_ki     = '0;
        cur_kd     = '0;
        cur_out_lo = LIMIT_MIN;
        cur_out_hi = LIMIT_MAX;
        cur_int_lo = LIMIT_MIN;
        cur_int_hi = LIMIT_MAX;
        cur_mode   = MODE_POSITIONAL;
        clear_history();
    endfunction

    function automatic void apply_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN_P:     cur_kp = data[GAIN_W-1:0];
            CFG_GAIN_I:     cur_ki = data[GAIN_W-1:0];
            CFG_GAIN_D:     cur_kd = data[GAIN_W-1:0];
            CFG_OUT_LOW:    cur_out_lo = data[LIMIT_W-1:0];
            CFG_OUT_HIGH:   cur_out_hi = data[LIMIT_W-1:0];
            CFG_INTEG_LOW:  cur_int_lo = data[LIMIT_W-1:0];
            CFG_INTEG_HIGH: cur_int_hi = data[LIMIT_W-1:0];
            CFG_LOOP_MODE:  cur_mode = data[0];
            default: ;
        endcase
        clear_history();
    endfunction

    // One controller update: returns the terms and drive, advances the state.
    function automatic pid_result_t compute_update(logic cmd,
                                                   logic signed [SAMPLE_W-1:0] tgt,
                                                   logic signed [SAMPLE_W-1:0] meas);
        pid_result_t res;
        longint e, pv, iv, dv, integ, total, clamped;
        res = '0;
        if (cmd == CMD_CLEAR)
        begin
            clear_history();
            return res;
        end
        e = longint'(tgt) - longint'(meas);
        if ((e < 0 ? -e : e) < longint'(DEADZONE_DEFAULT))
            e = 0;
        if (cur_mode == MODE_POSITIONAL)
        begin
            integ = clamp_to(longint'(integ_acc) + e, longint'(cur_int_lo),
                             longint'(cur_int_hi));
            integ_acc = integ[LIMIT_W-1:0];
            pv = (longint'(cur_kp) * e) >>> FRAC_W;
            iv = (longint'(cur_ki) * integ) >>> FRAC_W;
            dv = (longint'(cur_kd) * (e - longint'(err_last))) >>> FRAC_W;
            clamped = clamp_to(pv + iv + dv, longint'(cur_out_lo), longint'(cur_out_hi));
            err_last = e[ERR_W-1:0];
        end
        else
        begin
            pv = (longint'(cur_kp) * (e - longint'(err_last))) >>> FRAC_W;
            iv = (longint'(cur_ki) * e) >>> FRAC_W;
            dv = (longint'(cur_kd) * (e - 2 * longint'(err_last) + longint'(err_prev)))
                 >>> FRAC_W;
            total = longint'(held_drive) + pv + iv + dv;
            clamped = clamp_to(total, longint'(cur_out_lo), longint'(cur_out_hi));
            // Anti-windup: the held output only moves when no clamp acted.
            if (clamped == total)
                held_drive = clamped[LIMIT_W-1:0];
            err_prev = err_last;
            err_last = e[ERR_W-1:0];
        end
        res.p     = pv[TERM_W-1:0];
        res.i     = iv[TERM_W-1:0];
        res.d     = dv[TERM_W-1:0];
        res.drive = clamped[LIMIT_W-1:0];
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_reg_value(cfg_index_t idx);
        logic [CFG_DATA_W-1:0] v;
        int pick;
        v = $urandom;
        pick = $urandom_range(0, 9);
        case (idx)
            CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D:
                if (pick == 0)
                    v[GAIN_W-1:0] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                else if (pick < 6)
                    v[GAIN_W-1:0] = 16'($urandom_range(0, 1023)) - 16'd512;
            CFG_LOOP_MODE: ;
            default:
                if (pick == 0)
                    v = $urandom_range(0, 1) ? LIMIT_MAX : LIMIT_MIN;
                else if (pick < 4)
                    v = 32'($urandom_range(0, 131071)) - 32'd65536;
                else if (pick < 7)
                    v = 32'($urandom_range(0, 33554431)) - 32'd16777216;
        endcase
        return v;
    endfunction

    function automatic void add_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        row_t r;
        r = '{kind: ROW_WRITE, idx: idx, data: data, cmd: CMD_UPDATE, tgt: '0,
              meas: '0, typed: 1'b0, want: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_sample(logic cmd, logic signed [SAMPLE_W-1:0] tgt,
                                       logic signed [SAMPLE_W-1:0] meas);
        row_t r;
        r = '{kind: ROW_SAMPLE, idx: CFG_GAIN_P, data: '0, cmd: cmd, tgt: tgt,
              meas: meas, typed: 1'b0, want: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_known(logic cmd, logic signed [SAMPLE_W-1:0] tgt,
                                      logic signed [SAMPLE_W-1:0] meas,
                                      longint p, longint i, longint d, longint drv);
        row_t r;
        r = '{kind: ROW_SAMPLE, idx: CFG_GAIN_P, data: '0, cmd: cmd, tgt: tgt,
              meas: meas, typed: 1'b1, want: '0};
        r.want.p     = p[TERM_W-1:0];
        r.want.i     = i[TERM_W-1:0];
        r.want.d     = d[TERM_W-1:0];
        r.want.drive = drv[LIMIT_W-1:0];
        directed_rows.push_back(r);
    endfunction

    // Drops both request lines and waits until every result has come back.
    task automatic drain_to_idle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        drain_to_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_write(idx, data);
    endtask

    // Valid is left high after acceptance; the next call either lowers it
    // for a gap or presents the next request in the same step.
    task automatic send_sample(logic cmd, logic signed [SAMPLE_W-1:0] tgt,
                               logic signed [SAMPLE_W-1:0] meas,
                               bit typed, pid_result_t want);
        int gap;
        pid_result_t predicted;
        gap = pick_gap();
        cfg_valid <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        target   <= tgt;
        measured <= meas;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = compute_update(cmd, tgt, meas);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Result side: random stalls and the comparison against the oldest
    // expectation.
    initial
    begin
        int stall_left;
        pid_result_t want;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_valid && out_ready)
                begin
                    if (pending_results.size() == 0)
                        report_mismatch("result request with nothing expected");
                    else
                    begin
                        want = pending_results.pop_front();
                        if (p_term !== want.p)
                            report_mismatch($sformatf("p_term %0d, expected %0d",
                                                      p_term, want.p));
                        if (i_term !== want.i)
                            report_mismatch($sformatf("i_term %0d, expected %0d",
                                                      i_term, want.i));
                        if (d_term !== want.d)
                            report_mismatch($sformatf("d_term %0d, expected %0d",
                                                      d_term, want.d));
                        if (drive !== want.drive)
                            report_mismatch($sformatf("drive %0d, expected %0d",
                                                      drive, want.drive));
                    end
                end
                if (stall_left > 0)
                begin
                    out_ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    out_ready <= 1'b1;
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [SAMPLE_W-1:0] tgt, meas;
        logic cmd;

        reset_settings();

        // Zero gains after reset give an all-zero result whatever the sample.
        add_known(CMD_UPDATE, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0);
        add_known(CMD_UPDATE, 16'sh8000, 16'sh7FFF, 0, 0, 0, 0);
        add_known(CMD_CLEAR, 16'sh1234, 16'sh4321, 0, 0, 0, 0);
        // Unity proportional gain: the drive equals the error.
        add_write(CFG_GAIN_P, 32'h0000_0100);
        add_known(CMD_UPDATE, 16'sd100, 16'sd0, 100, 0, 0, 100);
        add_known(CMD_UPDATE, 16'sh7FFF, 16'sh8000, 65535, 0, 0, 65535);
        add_known(CMD_UPDATE, 16'sh8000, 16'sh7FFF, -65535, 0, 0, -65535);
        // Extreme gains.
        add_write(CFG_GAIN_P, 32'hFFFF_8000);
        add_write(CFG_GAIN_I, 32'h0000_7FFF);
        add_write(CFG_GAIN_D, 32'h5A5A_8000);
        add_sample(CMD_UPDATE, 16'sh7FFF, 16'sh8000);
        add_sample(CMD_UPDATE, 16'sh7FFF, 16'sh8000);
        add_sample(CMD_UPDATE, 16'sh8000, 16'sh7FFF);
        add_sample(CMD_UPDATE, 16'sd5, 16'sd5);
        // Integral limits written in reverse order.
        add_write(CFG_INTEG_LOW, 32'd300);
        add_write(CFG_INTEG_HIGH, -32'sd300);
        add_sample(CMD_UPDATE, 16'sd1000, 16'sd0);
        add_sample(CMD_UPDATE, 16'sd1000, 16'sd0);
        add_sample(CMD_UPDATE, -16'sd3, 16'sd0);
        // Output limits written in reverse order.
        add_write(CFG_OUT_LOW, 32'd5000);
        add_write(CFG_OUT_HIGH, -32'sd5000);
        add_sample(CMD_UPDATE, 16'sd7, 16'sd0);
        add_sample(CMD_UPDATE, -16'sd7, 16'sd0);
        // Incremental form with full-range limits, a clear in the middle.
        add_write(CFG_OUT_LOW, LIMIT_MIN);
        add_write(CFG_OUT_HIGH, LIMIT_MAX);
        add_write(CFG_INTEG_LOW, LIMIT_MIN);
        add_write(CFG_INTEG_HIGH, LIMIT_MAX);
        add_write(CFG_GAIN_P, 32'h0000_0100);
        add_write(CFG_GAIN_I, 32'h0000_0080);
        add_write(CFG_GAIN_D, 32'h0000_0040);
        add_write(CFG_LOOP_MODE, 32'(MODE_INCREMENTAL));
        add_sample(CMD_UPDATE, 16'sd10, 16'sd0);
        add_sample(CMD_UPDATE, 16'sd20, 16'sd0);
        add_sample(CMD_UPDATE, -16'sd40, 16'sd0);
        add_known(CMD_CLEAR, 16'sh7FFF, 16'sh8000, 0, 0, 0, 0);
        add_sample(CMD_UPDATE, 16'sh7FFF, 16'sh8000);
        // Tight output limits so the held output stops following the sum.
        add_write(CFG_OUT_LOW, -32'sd100);
        add_write(CFG_OUT_HIGH, 32'd100);
        add_sample(CMD_UPDATE, 16'sd50, 16'sd0);
        add_sample(CMD_UPDATE, 16'sd50, 16'sd0);
        add_sample(CMD_UPDATE, 16'sd50, 16'sd0);
        add_sample(CMD_UPDATE, -16'sd50, 16'sd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_WRITE)
                write_reg(directed_rows[k].idx, directed_rows[k].data);
            else
                send_sample(directed_rows[k].cmd, directed_rows[k].tgt,
                            directed_rows[k].meas, directed_rows[k].typed,
                            directed_rows[k].want);
        end

        setpoint = '0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            steady = ($urandom_range(0, 3) == 0);
            for (int r = int'(CFG_GAIN_P); r < int'(CFG_LOOP_MODE); r++)
                if ($urandom_range(0, 2) == 0)
                    write_reg(cfg_index_t'(r), rand_reg_value(cfg_index_t'(r)));
            write_reg(CFG_LOOP_MODE, {31'($urandom), 1'b0} | 32'(phase % 2));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 3 && n == ITEMS_PER_PHASE / 2)
                    drain_to_idle();
                cmd = CMD_UPDATE;
                case ($urandom_range(0, 19))
                    0:
                    begin
                        cmd  = CMD_CLEAR;
                        tgt  = 16'($urandom);
                        meas = 16'($urandom);
                    end
                    1, 2, 3, 4, 5:
                    begin
                        tgt  = 16'($urandom);
                        meas = 16'($urandom);
                    end
                    default:
                    begin
                        // Setpoint held for a while, measurement close to it.
                        if ($urandom_range(0, 19) == 0)
                            setpoint = 16'($urandom);
                        tgt  = setpoint;
                        meas = setpoint + 16'($urandom_range(0, 64)) - 16'sd32;
                    end
                endcase
                send_sample(cmd, tgt, meas, 1'b0, '0);
            end
        end

        drain_to_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pidpi_pkg.sv
rtl/pidpi_cfg.sv
rtl/pidpi_err_stage.sv
rtl/pidpi_mult_stage.sv
rtl/pidpi_out_stage.sv
rtl/pid_positional_incremental.sv
dv/tb.sv
